// File: hw/rtl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// No dependencies; imported by spq_cell and sorted_priority_queue.
`default_nettype none

package spq_pkg;

    // Field widths fixed by the word format
    localparam int VALUE_W       = 32;
    localparam int RANK_W        = 16;
    localparam int FILL_W        = 5;
    localparam int DEFAULT_DEPTH = 16;

    // Packed stream word widths
    localparam int S_DATA_W = 48;   // value, rank
    localparam int S_USER_W = 2;    // action
    localparam int M_DATA_W = 56;   // value, rank, fill level, zero pad
    localparam int M_USER_W = 3;    // status, out valid

    // Operation codes (code 3 behaves as a peek)
    typedef enum logic [1:0] {
        ACT_PUSH = 2'd0,
        ACT_POP  = 2'd1,
        ACT_PEEK = 2'd2
    } t_action;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Broadcast to every cell of the chain
    typedef struct packed {
        logic                      push;
        logic                      pop;
        logic signed [VALUE_W-1:0] new_value;
        logic        [RANK_W-1:0]  new_rank;
    } t_cell_ctrl;

endpackage : spq_pkg

`default_nettype wire

// File: hw/rtl/spq_cell.sv
// One slot of the sorted chain: holds an entry, compares it with the word
// being pushed and takes the new word or its left or right neighbour's entry. Needs spq_pkg.
`default_nettype none

module spq_cell (
    input  wire                                i_clk,
    input  wire  spq_pkg::t_cell_ctrl          i_ctrl,
    input  wire                                i_valid,      // slot holds an entry
    input  wire                                i_tie_keeps,  // equal rank stays put
    input  wire                                i_left_keep,
    input  wire  signed [spq_pkg::VALUE_W-1:0] i_left_value,
    input  wire         [spq_pkg::RANK_W-1:0]  i_left_rank,
    input  wire  signed [spq_pkg::VALUE_W-1:0] i_right_value,
    input  wire         [spq_pkg::RANK_W-1:0]  i_right_rank,
    output logic                               o_keep,
    output logic signed [spq_pkg::VALUE_W-1:0] o_value,
    output logic        [spq_pkg::RANK_W-1:0]  o_rank
);
    import spq_pkg::*;

    logic signed [VALUE_W-1:0] r_value;
    logic        [RANK_W-1:0]  r_rank;
    logic signed [VALUE_W-1:0] n_value;
    logic        [RANK_W-1:0]  n_rank;

    // Entry stays in place when it sorts ahead of the new word
    always_comb begin
        o_keep = i_valid && ((r_rank < i_ctrl.new_rank) ||
                             (i_tie_keeps && (r_rank == i_ctrl.new_rank)));
    end

    // Insert, shift up on push, shift down on pop
    always_comb begin
        n_value = r_value;
        n_rank  = r_rank;
        if (i_ctrl.push && !o_keep) begin
            if (i_left_keep) begin
                n_value = i_ctrl.new_value;
                n_rank  = i_ctrl.new_rank;
            end else begin
                n_value = i_left_value;
                n_rank  = i_left_rank;
            end
        end else if (i_ctrl.pop) begin
            n_value = i_right_value;
            n_rank  = i_right_rank;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_rank  <= n_rank;
    end

    assign o_value = r_value;
    assign o_rank  = r_rank;

endmodule : spq_cell

`default_nettype wire

// File: hw/rtl/sorted_priority_queue.sv
// Top level of the sorted priority queue: fill count, chain of spq_cell
// slots, result formatting and output register. Needs spq_pkg, spq_cell.
//
//  Channel  | Dir | Word contents (low bit first)
//  ---------+-----+------------------------------------------------------
//  s_axis   | in  | tdata: item_value[31:0], item_rank[47:32]
//           |     | tuser: action[1:0]
//  m_axis   | out | tdata: out_value[31:0], out_rank[47:32],
//           |     |        fill_level[52:48], zero pad[55:53]
//           |     | tuser: status[1:0], out_valid[2]
//
// One word per cycle while m_axis does not stall: every cell compares against
// the pushed rank and shifts in the same cycle. The result is registered and
// appears on m_axis in the cycle after acceptance.
// s_axis is ready whenever the output register is empty or being drained;
// a stall on m_axis holds the result and back-pressures s_axis.
// Reset (synchronous, active low) empties the queue; slot contents are
// left as they are and never read before being written.
`default_nettype none

module sorted_priority_queue #(
    parameter int QUEUE_DEPTH = spq_pkg::DEFAULT_DEPTH
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  wire  [spq_pkg::S_DATA_W-1:0]   i_s_axis_tdata,   // item_value, item_rank
    input  wire  [spq_pkg::S_USER_W-1:0]   i_s_axis_tuser,   // action
    output logic                           o_m_axis_tvalid,
    input  wire                            i_m_axis_tready,
    output logic [spq_pkg::M_DATA_W-1:0]   o_m_axis_tdata,   // out_value, out_rank, fill_level
    output logic [spq_pkg::M_USER_W-1:0]   o_m_axis_tuser    // status, out_valid
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Input unpacking
    t_action                   w_action;
    logic signed [VALUE_W-1:0] w_in_value;
    logic        [RANK_W-1:0]  w_in_rank;
    assign w_action   = t_action'(i_s_axis_tuser);
    assign w_in_value = i_s_axis_tdata[VALUE_W-1:0];
    assign w_in_rank  = i_s_axis_tdata[VALUE_W+RANK_W-1:VALUE_W];

    logic             w_accept;
    logic             w_full;
    logic             w_empty;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    t_cell_ctrl       w_ctrl;

    assign o_s_axis_tready = !o_m_axis_tvalid || i_m_axis_tready;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_full          = (r_count == CNT_W'(QUEUE_DEPTH));
    assign w_empty         = (r_count == '0);

    // Chain control
    always_comb begin
        w_ctrl.push      = w_accept && (w_action == ACT_PUSH) && !w_full;
        w_ctrl.pop       = w_accept && (w_action == ACT_POP) && !w_empty;
        w_ctrl.new_value = w_in_value;
        w_ctrl.new_rank  = w_in_rank;
    end

    // Fill count
    always_comb begin
        n_count = r_count;
        if (w_ctrl.push) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_ctrl.pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Cell chain
    logic                      w_keep  [QUEUE_DEPTH];
    logic signed [VALUE_W-1:0] w_value [QUEUE_DEPTH];
    logic        [RANK_W-1:0]  w_rank  [QUEUE_DEPTH];

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            logic                      w_lkeep;
            logic signed [VALUE_W-1:0] w_lvalue;
            logic        [RANK_W-1:0]  w_lrank;
            logic signed [VALUE_W-1:0] w_rvalue;
            logic        [RANK_W-1:0]  w_rrank;
            logic                      w_slot_valid;

            // head slot takes the new word on a push whenever it does not keep
            if (g == 0) begin : g_head
                assign w_lkeep  = 1'b1;
                assign w_lvalue = w_in_value;
                assign w_lrank  = w_in_rank;
            end else begin : g_body
                assign w_lkeep  = w_keep[g-1];
                assign w_lvalue = w_value[g-1];
                assign w_lrank  = w_rank[g-1];
            end

            if (g == QUEUE_DEPTH - 1) begin : g_tail
                assign w_rvalue = w_value[g];
                assign w_rrank  = w_rank[g];
            end else begin : g_mid
                assign w_rvalue = w_value[g+1];
                assign w_rrank  = w_rank[g+1];
            end

            assign w_slot_valid = (CNT_W'(g) < r_count);

            spq_cell u_cell (
                .i_clk         (i_clk),
                .i_ctrl        (w_ctrl),
                .i_valid       (w_slot_valid),
                .i_tie_keeps   (g == 0),
                .i_left_keep   (w_lkeep),
                .i_left_value  (w_lvalue),
                .i_left_rank   (w_lrank),
                .i_right_value (w_rvalue),
                .i_right_rank  (w_rrank),
                .o_keep        (w_keep[g]),
                .o_value       (w_value[g]),
                .o_rank        (w_rank[g])
            );
        end
    endgenerate

    // Result word
    t_status                   w_status;
    logic                      w_res_valid;
    logic signed [VALUE_W-1:0] w_res_value;
    logic        [RANK_W-1:0]  w_res_rank;

    always_comb begin
        w_status    = ST_OK;
        w_res_valid = 1'b1;
        w_res_value = w_value[0];
        w_res_rank  = w_rank[0];
        case (w_action)
            ACT_PUSH: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else if (!w_keep[0]) begin
                    // new word becomes the head
                    w_res_value = w_in_value;
                    w_res_rank  = w_in_rank;
                end
            end
            default: begin
                // pop reports the old head, peek the current one
                if (w_empty) begin
                    w_status    = ST_EMPTY;
                    w_res_valid = 1'b0;
                    w_res_value = '0;
                    w_res_rank  = '0;
                end
            end
        endcase
    end

    // Output register
    logic                r_m_valid;
    logic [M_DATA_W-1:0] r_m_data;
    logic [M_USER_W-1:0] r_m_user;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_accept) begin
            r_m_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_m_data <= {(M_DATA_W-VALUE_W-RANK_W-FILL_W)'(0), FILL_W'(n_count),
                         w_res_rank, w_res_value};
            r_m_user <= {w_res_valid, w_status};
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;
    assign o_m_axis_tuser  = r_m_user;

endmodule : sorted_priority_queue

`default_nettype wire
